FILE: rtl/core/multiplexed_seven_segment_driver_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment driver
// Shared check forms, all clocked on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTIPLEXED_SEVEN_SEGMENT_DRIVER_MACROS_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_DRIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSD_ASSERT_SAME(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSD_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

FILE: rtl/core/msd_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment driver package
// Widths, display codes, mode and register codes, and divider handshake types.
// ----------------------------------------------------------------------------
package msd_pkg;

	localparam int VALUE_W       = 64;
	localparam int CODE_W        = 5;
	localparam int DIGIT_W       = 4;
	localparam int BASE_W        = 5;
	localparam int DIV_STEP_BITS = 8;
	localparam int DIV_CYCLES    = VALUE_W / DIV_STEP_BITS;
	localparam int MAX_DIGITS_DEF = 8;

	localparam logic [CODE_W-1:0] CODE_MINUS = 5'd16;
	localparam logic [CODE_W-1:0] CODE_BLANK = 5'd17;
	localparam logic [CODE_W-1:0] CODE_ZERO  = 5'd0;

	localparam logic [BASE_W-1:0] BASE_DEC = 5'd10;
	localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

	localparam logic [3:0] DIGIT_COUNT_RST = 4'd8;
	localparam logic signed [3:0] POINT_NONE = -4'sd1;

	typedef enum logic [1:0] {
		MODE_LOAD_DEC = 2'd0,
		MODE_LOAD_HEX = 2'd1,
		MODE_TICK     = 2'd2,
		MODE_CLEAR    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_DIGIT_COUNT = 2'd0,
		CFG_ZERO_FILL   = 2'd1,
		CFG_ALLOW_SIGN  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic              start;
		logic [BASE_W-1:0] base;
	} div_req_t;

	typedef struct packed {
		logic done;
	} div_rsp_t;

endpackage

FILE: rtl/core/msd_divider.sv
// ----------------------------------------------------------------------------
// Digit divider
// Restoring division of a 64-bit word by a small base, eight bits per cycle.
// ----------------------------------------------------------------------------
module msd_divider
	import msd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  div_req_t           req,
	input  logic [VALUE_W-1:0] dividend,
	output div_rsp_t           rsp,
	output logic [VALUE_W-1:0] quotient,
	output logic [DIGIT_W-1:0] remainder
);

	localparam int CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

	logic [VALUE_W-1:0] acc_q, acc_nxt;
	logic [BASE_W-1:0]  rem_q, rem_nxt;
	logic [BASE_W-1:0]  base_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	// The partial remainder stays below the base, so one shifted-in bit never
	// overflows its five bits. Quotient bits enter the accumulator from below.
	always_comb begin
		acc_nxt = acc_q;
		rem_nxt = rem_q;
		for (int k = 0; k < DIV_STEP_BITS; k++) begin
			rem_nxt = {rem_nxt[BASE_W-2:0], acc_nxt[VALUE_W-1]};
			acc_nxt = {acc_nxt[VALUE_W-2:0], 1'b0};
			if (rem_nxt >= base_q) begin
				rem_nxt    = rem_nxt - base_q;
				acc_nxt[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q  <= dividend;
			rem_q  <= '0;
			base_q <= req.base;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done  = done_q;
	assign quotient  = acc_q;
	assign remainder = rem_q[DIGIT_W-1:0];

endmodule

FILE: rtl/core/multiplexed_seven_segment_driver.sv
// Scan ticks and clears register their result beat at the accept edge.
// A load runs the divider once per converted digit, then a finishing state writes the fill,
// sign and point and delivers its result beat once the output register is free.
// The block takes no new beat while a load converts or a result is held by stall.
// Reset (arst_n low, asynchronous) blanks every digit, stops scanning, puts the
// cursor at 0, clears the point and restores the registers to 8 digits, blank fill, no sign.
// ----------------------------------------------------------------------------
// Multiplexed seven-segment driver
// Converts decimal or hex loads into a digit store with a shared divider and
// scans the store out one digit per tick.
// ----------------------------------------------------------------------------
`include "multiplexed_seven_segment_driver_macros.svh"

module multiplexed_seven_segment_driver
	import msd_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write port.
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [3:0]         cfg_data,
	// Item channel.
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         mode,
	input  logic [VALUE_W-1:0] value,
	input  logic signed [3:0]  point_position,
	// Result channel.
	output logic               result_valid,
	input  logic               result_stall,
	output logic [2:0]         digit_index,
	output logic [CODE_W-1:0]  digit_code,
	output logic               point_on,
	output logic               digit_enabled,
	output logic               load_error
);

	// CNT_W holds a digit count up to MAX_DIGITS; IDX_W addresses the store.
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DIVIDE = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [3:0] digit_count_q;
	logic       zero_fill_q;
	logic       allow_sign_q;

	// Display state.
	logic [CODE_W-1:0]  store_q [MAX_DIGITS];
	logic [IDX_W-1:0]   cursor_q;
	logic signed [3:0]  point_q;
	logic               stopped_q;

	// Load context, held while the divider works through the digits.
	logic               minus_q;
	logic signed [3:0]  point_ld_q;
	logic [BASE_W-1:0]  base_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   nd_q;
	logic               err_q;

	// Result register.
	logic               result_valid_q;
	logic [2:0]         res_index_q;
	logic [CODE_W-1:0]  res_code_q;
	logic               res_point_q;
	logic               res_enabled_q;
	logic               res_error_q;

	// Divider connection.
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic [VALUE_W-1:0] div_dividend;
	logic [VALUE_W-1:0] div_quotient;
	logic [DIGIT_W-1:0] div_rem;

	logic               out_free;
	logic               accept;
	logic               res_load;
	mode_t              mode_in;
	logic               is_load;
	logic [VALUE_W-1:0] load_mag;
	logic [CNT_W-1:0]   n_att;
	logic [CNT_W-1:0]   idx_next;
	logic               more_digits;
	logic               too_long;
	logic [CNT_W-1:0]   tick_next;
	logic [IDX_W-1:0]   tick_idx;
	logic [CODE_W-1:0]  tick_code;
	logic               tick_point;
	logic               sign_err;
	logic               fin_err;
	logic [CNT_W-1:0]   sign_pos;

	// The output register frees up in the same cycle its beat is taken, so a
	// tick can land right behind a result that leaves.
	assign out_free   = !result_valid_q || !result_stall;
	assign item_stall = (state_q != ST_IDLE) || !out_free;
	assign accept     = item_valid && !item_stall;
	assign mode_in    = mode_t'(mode);
	assign is_load    = (mode_in == MODE_LOAD_DEC) || (mode_in == MODE_LOAD_HEX);

	// A new result beat enters the output register for a tick or clear at its
	// accept edge, and for a load when it finishes.
	assign res_load = (accept && !is_load) || (state_q == ST_FINISH && out_free);

	// Decimal loads show the magnitude; the most negative value negates to 2^63
	// which is still correct as an unsigned 64-bit word.
	assign load_mag = (mode_in == MODE_LOAD_DEC && value[VALUE_W-1]) ?
		(~value + 1'b1) : value;

	// Attached digits: the register saturated to 1..MAX_DIGITS.
	always_comb begin
		if (digit_count_q == 4'd0) begin
			n_att = CNT_W'(1);
		end else if (int'(digit_count_q) > MAX_DIGITS) begin
			n_att = CNT_W'(MAX_DIGITS);
		end else begin
			n_att = CNT_W'(digit_count_q);
		end
	end

	// After each digit: stop when the quotient is exhausted, flag an overflow
	// when digits remain but every attached position is already used.
	assign idx_next    = idx_q + 1'b1;
	assign more_digits = (div_quotient != '0);
	assign too_long    = more_digits && (idx_next >= n_att);

	always_comb begin
		div_req.start = 1'b0;
		div_req.base  = base_q;
		div_dividend  = div_quotient;
		if (state_q == ST_IDLE) begin
			div_req.start = accept && is_load;
			div_req.base  = (mode_in == MODE_LOAD_DEC) ? BASE_DEC : BASE_HEX;
			div_dividend  = load_mag;
		end else if (state_q == ST_DIVIDE) begin
			div_req.start = div_rsp.done && more_digits && !too_long;
		end
	end

	msd_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.dividend  (div_dividend),
		.rsp       (div_rsp),
		.quotient  (div_quotient),
		.remainder (div_rem)
	);

	// Scan tick: advance the cursor with wrap at the attached count. A cursor
	// left past a shrunken count also wraps to digit 0 here.
	always_comb begin
		tick_next = CNT_W'(cursor_q) + 1'b1;
		if (tick_next >= n_att) begin
			tick_next = '0;
		end
	end
	assign tick_idx   = tick_next[IDX_W-1:0];
	assign tick_code  = store_q[tick_idx];
	assign tick_point = !point_q[3] && (int'(tick_idx) == int'(point_q[2:0]));

	// Finishing a load: a sign that needs a free position but finds none turns
	// into the dash pattern, like a number that is too long.
	assign sign_err = minus_q && allow_sign_q && (nd_q == n_att);
	assign fin_err  = err_q || sign_err;
	assign sign_pos = zero_fill_q ? (n_att - 1'b1) : nd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			digit_count_q  <= DIGIT_COUNT_RST;
			zero_fill_q    <= 1'b0;
			allow_sign_q   <= 1'b0;
			for (int j = 0; j < MAX_DIGITS; j++) begin
				store_q[j] <= CODE_BLANK;
			end
			cursor_q       <= '0;
			point_q        <= POINT_NONE;
			stopped_q      <= 1'b1;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_idx_t'(cfg_index))
					CFG_DIGIT_COUNT: digit_count_q <= cfg_data;
					CFG_ZERO_FILL:   zero_fill_q   <= cfg_data[0];
					CFG_ALLOW_SIGN:  allow_sign_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end

			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (mode_in)
							MODE_LOAD_DEC, MODE_LOAD_HEX: begin
								state_q <= ST_DIVIDE;
							end
							MODE_TICK: begin
								if (!stopped_q) begin
									cursor_q <= tick_idx;
								end
							end
							MODE_CLEAR: begin
								stopped_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIVIDE: begin
					if (div_rsp.done) begin
						// Digit positions past the attached count are never written.
						store_q[idx_q[IDX_W-1:0]] <= CODE_W'(div_rem);
						if (!more_digits || too_long) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q        <= ST_IDLE;
						cursor_q       <= '0;
						stopped_q      <= 1'b0;
						point_q        <= fin_err ? POINT_NONE : point_ld_q;
						for (int j = 0; j < MAX_DIGITS; j++) begin
							if (j < int'(n_att)) begin
								if (fin_err) begin
									store_q[j] <= CODE_MINUS;
								end else if (minus_q && allow_sign_q &&
									j == int'(sign_pos)) begin
									store_q[j] <= CODE_MINUS;
								end else if (j >= int'(nd_q)) begin
									store_q[j] <= zero_fill_q ? CODE_ZERO : CODE_BLANK;
								end
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Load context and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			if (is_load) begin
				minus_q    <= (mode_in == MODE_LOAD_DEC) && value[VALUE_W-1];
				point_ld_q <= (mode_in == MODE_LOAD_DEC) ? point_position : POINT_NONE;
				base_q     <= div_req.base;
				idx_q      <= '0;
				err_q      <= 1'b0;
			end else if (mode_in == MODE_TICK && !stopped_q) begin
				res_index_q   <= 3'(tick_idx);
				res_code_q    <= tick_code;
				res_enabled_q <= (tick_code != CODE_BLANK);
				res_point_q   <= (tick_code != CODE_BLANK) && tick_point;
				res_error_q   <= 1'b0;
			end else begin
				res_index_q   <= 3'(cursor_q);
				res_code_q    <= CODE_BLANK;
				res_point_q   <= 1'b0;
				res_enabled_q <= 1'b0;
				res_error_q   <= 1'b0;
			end
		end

		if (state_q == ST_DIVIDE && div_rsp.done) begin
			idx_q <= idx_next;
			if (!more_digits) begin
				nd_q <= idx_next;
			end
			if (too_long) begin
				err_q <= 1'b1;
			end
		end

		if (state_q == ST_FINISH && out_free) begin
			res_index_q   <= 3'd0;
			res_code_q    <= CODE_BLANK;
			res_point_q   <= 1'b0;
			res_enabled_q <= 1'b0;
			res_error_q   <= fin_err;
		end
	end

	assign result_valid  = result_valid_q;
	assign digit_index   = res_index_q;
	assign digit_code    = res_code_q;
	assign point_on      = res_point_q;
	assign digit_enabled = res_enabled_q;
	assign load_error    = res_error_q;

	// A failed load always shows a dark digit 0 in its result beat.
	`MSD_ASSERT_SAME(a_error_beat, result_valid && load_error,
		!digit_enabled && digit_index == 3'd0 && !point_on, "load error beat with a driven digit")
	// A driven digit never carries the blank code, and a point needs a driven digit.
	`MSD_ASSERT_SAME(a_enable_code, result_valid && (digit_enabled || point_on),
		digit_enabled && digit_code != CODE_BLANK, "enable or point inconsistent with code")
	// The divider only reports back while a load is converting.
	`MSD_ASSERT_SAME(a_div_done, div_rsp.done, state_q == ST_DIVIDE,
		"divider done outside conversion")
	// A finishing load with a free output register hands over its beat at once.
	`MSD_ASSERT_NEXT(a_finish, state_q == ST_FINISH && out_free,
		state_q == ST_IDLE && result_valid && !stopped_q, "load finish did not deliver")

endmodule

FILE: dv/tb_multiplexed_seven_segment_driver.sv
// ----------------------------------------------------------------------------
// Testbench for the multiplexed seven-segment driver
// Drives decimal and hex loads, scan ticks and clears through the valid/stall
// item channel, predicts every result beat with a shadow digit store, and
// checks each beat field by field under random idling and output backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multiplexed_seven_segment_driver;
	import msd_pkg::*;

	localparam int          NUM_DIGITS    = MAX_DIGITS_DEF;
	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	// A load converts at most eight digits, one divider run each, then finishes.
	localparam int          DRAIN_CYCLES  = 200;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          PRINT_LIMIT   = 40;

	// One result beat as the block presents it.
	typedef struct packed {
		logic [2:0]        digit_index;
		logic [CODE_W-1:0] digit_code;
		logic              point_on;
		logic              digit_enabled;
		logic              load_error;
	} scan_beat_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_write;
	logic [1:0]         cfg_index;
	logic [3:0]         cfg_data;
	logic               item_valid;
	logic               item_stall;
	logic [1:0]         mode;
	logic [VALUE_W-1:0] value;
	logic signed [3:0]  point_position;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [2:0]         digit_index;
	logic [CODE_W-1:0]  digit_code;
	logic               point_on;
	logic               digit_enabled;
	logic               load_error;

	multiplexed_seven_segment_driver u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.mode           (mode),
		.value          (value),
		.point_position (point_position),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.digit_index    (digit_index),
		.digit_code     (digit_code),
		.point_on       (point_on),
		.digit_enabled  (digit_enabled),
		.load_error     (load_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the block: digit store, scan cursor, point, stop flag and
	// the three registers. It advances once per accepted item beat.
	// ------------------------------------------------------------------
	logic [CODE_W-1:0] shadow_digits [NUM_DIGITS];
	int unsigned       shadow_cursor;
	int                shadow_point;
	bit                shadow_stopped;
	logic [3:0]        reg_digit_count;
	bit                reg_zero_fill;
	bit                reg_allow_sign;

	// Beats still owed by the block, oldest first.
	scan_beat_t        pending_beats [$];

	int unsigned mismatches   = 0;
	int unsigned beats_seen   = 0;
	int unsigned loads_sent   = 0;
	int unsigned overflows    = 0;
	int unsigned lit_ticks    = 0;
	int unsigned settings_run = 0;
	int unsigned cycle_count  = 0;

	// Shared with the output side: no idling on either side while set.
	bit          calm_stretch = 1'b0;
	// Bumped by a test to ask the output side for one long hold-off.
	int unsigned hold_serial  = 0;
	int unsigned hold_seen    = 0;
	int unsigned hold_left    = 0;

	// Appends one predicted beat at the tail of the pending list.
	function automatic void queue_prediction(scan_beat_t beat);
		pending_beats.insert(pending_beats.size(), beat);
	endfunction

	// The register is four bits wide but the display has at most eight digits;
	// zero and anything past the top saturate.
	function automatic int unsigned attached_digits();
		if (reg_digit_count < 1)
			return 1;
		if (reg_digit_count > NUM_DIGITS)
			return NUM_DIGITS;
		return int'(reg_digit_count);
	endfunction

	// The overflow pattern: dashes on every attached digit, no point, scan restarts.
	function automatic void show_dashes(int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			shadow_digits[i] = CODE_MINUS;
		shadow_cursor  = 0;
		shadow_stopped = 1'b0;
		shadow_point   = -1;
	endfunction

	// Writes the digits of mag into the shadow store; returns 1 when it does not fit.
	function automatic bit convert_number(logic [63:0] mag, int unsigned base, bit minus,
			int point);
		int unsigned n;
		int unsigned nd;
		logic [63:0] rest;
		n    = attached_digits();
		nd   = 1;
		rest = mag / base;
		while (rest > 0) begin
			nd++;
			rest = rest / base;
		end
		if (nd > n) begin
			show_dashes(n);
			return 1'b1;
		end
		for (int unsigned i = 0; i < nd; i++) begin
			shadow_digits[i] = CODE_W'(mag % base);
			mag = mag / base;
		end
		for (int unsigned i = nd; i < n; i++)
			shadow_digits[i] = reg_zero_fill ? CODE_ZERO : CODE_BLANK;
		// A sign needs a free digit: the top one when zero-filling, else the one
		// just above the number.
		if (minus && reg_allow_sign) begin
			if (nd == n) begin
				show_dashes(n);
				return 1'b1;
			end
			shadow_digits[reg_zero_fill ? n - 1 : nd] = CODE_MINUS;
		end
		shadow_cursor  = 0;
		shadow_stopped = 1'b0;
		shadow_point   = point;
		return 1'b0;
	endfunction

	// Advances the shadow by one item and returns the beat the block must produce.
	function automatic scan_beat_t predict_scan_beat(mode_t m, logic [63:0] v,
			logic signed [3:0] p);
		scan_beat_t  beat;
		logic [63:0] mag;
		int unsigned n;
		beat = '0;
		beat.digit_code = CODE_BLANK;
		case (m)
			MODE_LOAD_DEC: begin
				// The most negative value negates to itself, which reads as 2^63 unsigned.
				mag = v[63] ? (~v + 64'd1) : v;
				beat.load_error = convert_number(mag, BASE_DEC, v[63], int'(p));
				loads_sent++;
			end
			MODE_LOAD_HEX: begin
				beat.load_error = convert_number(v, BASE_HEX, 1'b0, int'(POINT_NONE));
				loads_sent++;
			end
			MODE_TICK: begin
				if (!shadow_stopped) begin
					n = attached_digits();
					// A cursor left past a shrunken digit count wraps here too.
					shadow_cursor++;
					if (shadow_cursor >= n)
						shadow_cursor = 0;
					beat.digit_code = shadow_digits[shadow_cursor];
					if (beat.digit_code != CODE_BLANK) begin
						beat.digit_enabled = 1'b1;
						beat.point_on = (shadow_point >= 0) && (shadow_point == shadow_cursor);
						lit_ticks++;
					end
				end
			end
			MODE_CLEAR: begin
				shadow_stopped = 1'b1;
			end
			default: begin
			end
		endcase
		if (beat.load_error)
			overflows++;
		beat.digit_index = shadow_cursor[2:0];
		return beat;
	endfunction

	// ------------------------------------------------------------------
	// Random stimulus helpers.
	// ------------------------------------------------------------------
	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic signed [3:0] rand_point();
		return 4'($urandom);
	endfunction

	// Mostly numbers that fit, some too wide, and some right at the edge of the
	// digit count; a third of decimal loads are negated.
	function automatic logic [63:0] load_value(bit decimal);
		logic [63:0] v;
		logic [63:0] span;
		int unsigned pick;
		int unsigned k;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			v = rand64() >> $urandom_range(38, 63);
		else if (pick < 8)
			v = rand64() >> $urandom_range(0, 37);
		else begin
			k    = $urandom_range(attached_digits() - 1, attached_digits());
			span = 64'd1;
			repeat (k) span = span * (decimal ? 64'd10 : 64'd16);
			v = span - 64'($urandom_range(0, 1));
		end
		if (decimal && $urandom_range(0, 2) == 0)
			v = ~v + 64'd1;
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Mismatch reporting: one line per bad field, printing capped.
	// ------------------------------------------------------------------
	task automatic report_mismatch(string field, longint got, longint want);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] beat %0d: %s is %0d, expected %0d", $realtime, beats_seen,
				field, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Sender. Entered and left at a falling edge. Valid stays high between
	// back-to-back beats, and is only dropped when a random gap is taken.
	// ------------------------------------------------------------------
	task automatic send_beat(mode_t m, logic [63:0] v, logic signed [3:0] p);
		if (!calm_stretch && $urandom_range(0, 99) < 6) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		item_valid     <= 1'b1;
		mode           <= m;
		value          <= v;
		point_position <= p;
		do
			@(posedge clk);
		while (item_stall);
		queue_prediction(predict_scan_beat(m, v, p));
		@(negedge clk);
	endtask

	// Writes all three registers back to back once the block has drained.
	task automatic apply_settings(logic [3:0] count, bit fill, bit sign);
		item_valid <= 1'b0;
		wait (pending_beats.size() == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_DIGIT_COUNT;
		cfg_data  <= count;
		@(posedge clk);
		reg_digit_count = count;
		@(negedge clk);
		cfg_index <= CFG_ZERO_FILL;
		cfg_data  <= {3'b000, fill};
		@(posedge clk);
		reg_zero_fill = fill;
		@(negedge clk);
		cfg_index <= CFG_ALLOW_SIGN;
		cfg_data  <= {3'b000, sign};
		@(posedge clk);
		reg_allow_sign = sign;
		@(negedge clk);
		cfg_write <= 1'b0;
		settings_run++;
	endtask

	// Mostly a load followed by a run of ticks, now and then a clear; the rest
	// is single items of any kind. It opens with ticks so that a cursor left
	// over from a larger digit count gets to wrap.
	task automatic drive_scan_traffic(int unsigned n_items);
		int unsigned sent;
		int unsigned ticks;
		mode_t       m;
		sent = 0;
		repeat ($urandom_range(1, 3)) begin
			send_beat(MODE_TICK, rand64(), rand_point());
			sent++;
		end
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 75) begin
				m = ($urandom_range(0, 4) < 3) ? MODE_LOAD_DEC : MODE_LOAD_HEX;
				send_beat(m, load_value(m == MODE_LOAD_DEC), rand_point());
				ticks = $urandom_range(1, 2 * attached_digits() + 1);
				repeat (ticks) send_beat(MODE_TICK, rand64(), rand_point());
				sent += ticks + 1;
				if ($urandom_range(0, 9) == 0) begin
					send_beat(MODE_CLEAR, rand64(), rand_point());
					send_beat(MODE_TICK, rand64(), rand_point());
					sent += 2;
				end
			end else begin
				send_beat(mode_t'($urandom_range(0, 3)), rand64(), rand_point());
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Straight out of reset the block is stopped: a tick and a clear both give
	// a blank, unlit beat at digit 0.
	task automatic test_idle_after_reset();
		send_beat(MODE_TICK, 64'd0, POINT_NONE);
		send_beat(MODE_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, -4'sd8);
	endtask

	// Reset settings: eight digits, blank fill, no sign.
	task automatic test_fill_and_blank();
		// Exactly eight digits fit; the point shows on digit 3.
		send_beat(MODE_LOAD_DEC, 64'd12345678, 4'sd3);
		repeat (3) send_beat(MODE_TICK, 64'd0, POINT_NONE);
		// Nine digits do not fit.
		send_beat(MODE_LOAD_DEC, 64'd123456789, 4'sd1);
		send_beat(MODE_TICK, 64'd0, POINT_NONE);
		// Sign is off, so only the magnitude shows; digit 1 is then blank.
		send_beat(MODE_LOAD_DEC, -64'sd5, -4'sd8);
		send_beat(MODE_TICK, 64'd0, POINT_NONE);
		send_beat(MODE_LOAD_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 4'sd7);
		send_beat(MODE_LOAD_HEX, 64'h89AB_CDEF, 4'sd2);
		send_beat(MODE_TICK, 64'd0, POINT_NONE);
		send_beat(MODE_LOAD_DEC, 64'h8000_0000_0000_0000, POINT_NONE);
		// A tick after a clear must not move the cursor.
		send_beat(MODE_CLEAR, 64'd0, POINT_NONE);
		send_beat(MODE_TICK, 64'd0, POINT_NONE);
	endtask

	// Sign in the top digit with zero fill, just above the number without it,
	// and the case where the sign has no room left.
	task automatic test_sign_placement();
		apply_settings(4'd4, 1'b1, 1'b1);
		send_beat(MODE_LOAD_DEC, -64'sd123, 4'sd0);
		repeat (3) send_beat(MODE_TICK, 64'd0, POINT_NONE);
		send_beat(MODE_LOAD_DEC, -64'sd1234, POINT_NONE);
		// Point at or past the digit count is never lit.
		send_beat(MODE_LOAD_DEC, 64'd7, 4'sd7);
		send_beat(MODE_TICK, 64'd0, POINT_NONE);
		send_beat(MODE_LOAD_DEC, 64'h7FFF_FFFF_FFFF_FFFF, POINT_NONE);
		apply_settings(4'd4, 1'b0, 1'b1);
		send_beat(MODE_LOAD_DEC, -64'sd12, 4'sd1);
		repeat (2) send_beat(MODE_TICK, 64'd0, POINT_NONE);
	endtask

	// Register extremes, including the counts that saturate.
	task automatic test_settings_sweep();
		apply_settings(4'd0, 1'b0, 1'b0);
		drive_scan_traffic(40);
		apply_settings(4'd15, 1'b1, 1'b1);
		drive_scan_traffic(40);
		apply_settings(4'd1, 1'b0, 1'b1);
		drive_scan_traffic(40);
		apply_settings(4'd1, 1'b1, 1'b0);
		drive_scan_traffic(40);
		apply_settings(4'd8, 1'b1, 1'b1);
		drive_scan_traffic(40);
		// Shrinking the count leaves the cursor past the end until the next tick.
		apply_settings(4'd3, 1'b0, 1'b1);
		drive_scan_traffic(40);
	endtask

	// The output side holds off for a long stretch while items keep coming,
	// so a result sits in the block and its input backs up.
	task automatic test_output_backpressure();
		apply_settings(4'd8, 1'b0, 1'b1);
		hold_serial++;
		send_beat(MODE_LOAD_DEC, -64'sd9876, 4'sd2);
		repeat (10) send_beat(MODE_TICK, rand64(), rand_point());
		send_beat(MODE_LOAD_HEX, 64'hDEAD, rand_point());
		repeat (6) send_beat(MODE_TICK, rand64(), rand_point());
	endtask

	// Bulk random phases under random settings; one phase runs with no idling.
	task automatic test_random_scan();
		for (int phase = 0; phase < 8; phase++) begin
			apply_settings(4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom));
			calm_stretch = (phase == 3);
			drive_scan_traffic(95);
		end
		calm_stretch = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Output side: random stall, the long hold-off on request, none while calm.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_serial != hold_seen) begin
			hold_seen    <= hold_serial;
			hold_left    <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (calm_stretch) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(0, 99) < 6);
		end
	end

	// Each accepted result beat is matched against the oldest prediction.
	always @(posedge clk) begin : check_results
		scan_beat_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_beats.size() == 0) begin
				report_mismatch("unexpected beat, digit_code", digit_code, CODE_BLANK);
			end else begin
				want = pending_beats.pop_front();
				if (digit_index !== want.digit_index)
					report_mismatch("digit_index", digit_index, want.digit_index);
				if (digit_code !== want.digit_code)
					report_mismatch("digit_code", digit_code, want.digit_code);
				if (point_on !== want.point_on)
					report_mismatch("point_on", point_on, want.point_on);
				if (digit_enabled !== want.digit_enabled)
					report_mismatch("digit_enabled", digit_enabled, want.digit_enabled);
				if (load_error !== want.load_error)
					report_mismatch("load_error", load_error, want.load_error);
			end
			beats_seen++;
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Watchdog: a hung handshake ends the run here.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles with %0d beats outstanding", cycle_count,
			pending_beats.size());
		$display("tb_multiplexed_seven_segment_driver: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		cfg_write      = 1'b0;
		cfg_index      = CFG_DIGIT_COUNT;
		cfg_data       = 4'd0;
		item_valid     = 1'b0;
		mode           = MODE_TICK;
		value          = '0;
		point_position = POINT_NONE;
		// Shadow state after reset.
		for (int i = 0; i < NUM_DIGITS; i++)
			shadow_digits[i] = CODE_BLANK;
		shadow_cursor   = 0;
		shadow_point    = -1;
		shadow_stopped  = 1'b1;
		reg_digit_count = DIGIT_COUNT_RST;
		reg_zero_fill   = 1'b0;
		reg_allow_sign  = 1'b0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_after_reset();
		test_fill_and_blank();
		test_sign_placement();
		test_settings_sweep();
		test_output_backpressure();
		test_random_scan();

		// Drain, then give the block time to show any stray beat.
		item_valid <= 1'b0;
		wait (pending_beats.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d result beats over %0d register settings in %0d cycles.",
			beats_seen, settings_run, cycle_count);
		$display("Loads: %0d, of which %0d overflowed; lit digits scanned: %0d.",
			loads_sent, overflows, lit_ticks);
		if (mismatches == 0) begin
			$display("tb_multiplexed_seven_segment_driver: PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb_multiplexed_seven_segment_driver: FAIL");
		end
		$finish;
	end

endmodule
